// ===== rtl/core/bqfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bqfr_pkg: shared types and constants for the biquad and frame rotation
// Register map, register reset values, fixed field widths and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package bqfr_pkg;

  localparam int COEFF_W   = 16;
  localparam int OUT_W     = 24;
  localparam int OUT_FRAC  = 20;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // Register indexes; the datapath sequencer walks the same codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_A = 3'd0,
    REG_COEFF_B = 3'd1,
    REG_COEFF_C = 3'd2,
    REG_COEFF_D = 3'd3,
    REG_COEFF_E = 3'd4,
    REG_ROT_X   = 3'd5,
    REG_ROT_Y   = 3'd6,
    REG_ROT_Z   = 3'd7
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][COEFF_W-1:0] coeff_bank_t;

  // Index 7 first.
  localparam coeff_bank_t CFG_RESET = {
    16'(0),       // rot_to_body_z
    16'(-8192),   // rot_to_body_y
    16'(14189),   // rot_to_body_x
    16'(7424),    // coeff_e
    16'(-20287),  // coeff_d
    16'(1530),    // coeff_c
    16'(1996),    // coeff_b
    16'(0)        // coeff_a
  };

  localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
  localparam logic signed [63:0] OUT_MIN = -64'sd8388608;

  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bqfr_if.sv =====
// ----------------------------------------------------------------------------
// bqfr_if: valid/ready channels for samples and results
// One interface per channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqfr_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bqfr_result_if;
  import bqfr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic signed [OUT_W-1:0] body_x;
  logic signed [OUT_W-1:0] body_y;
  logic signed [OUT_W-1:0] body_z;

  modport source (output valid, output filtered, output body_x, output body_y,
                  output body_z, input ready);
  modport sink   (input valid, input filtered, input body_x, input body_y,
                  input body_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqfr_front.sv =====
// ----------------------------------------------------------------------------
// bqfr_front: sample intake
// Takes sample transactions into a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfr_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  bqfr_sample_if.sink                         samples,
  output logic                                head_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      head_sample,
  input  wire logic                           pop
);
  import bqfr_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] entries [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign samples.ready = (count != 2'd2);
  assign push          = samples.valid && samples.ready;
  assign head_valid    = (count != 2'd0);
  assign take          = pop && head_valid;
  assign head_sample   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= samples.sample;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bqfr_back.sv =====
// ----------------------------------------------------------------------------
// bqfr_back: filter and rotation datapath
// One shared multiplier sequenced over five filter taps and three cosines.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfr_back #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] head_sample,
  output logic                                pop,
  input  wire bqfr_pkg::coeff_bank_t          coeffs,
  bqfr_result_if.source                       results
);
  import bqfr_pkg::*;

  localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;
  localparam int ALIGN_FRAC  = (SAMPLE_FRAC > OUT_FRAC) ? SAMPLE_FRAC : OUT_FRAC;
  localparam int U_SHIFT     = ALIGN_FRAC - SAMPLE_FRAC;
  localparam int Y_SHIFT     = ALIGN_FRAC - OUT_FRAC;
  localparam int SUM_DROP    = ALIGN_FRAC + COEFF_FRAC_BITS - OUT_FRAC;
  localparam int MUL_W       = (SAMPLE_WIDTH > OUT_W) ? SAMPLE_WIDTH : OUT_W;
  localparam int PROD_W      = COEFF_W + MUL_W;
  localparam int ACC_W       = ALIGN_FRAC + 23;

  localparam logic signed [ACC_W:0]  HALF_F = (ACC_W+1)'(1) <<< (SUM_DROP - 1);
  localparam logic signed [PROD_W:0] HALF_R = (PROD_W+1)'(1) <<< (COEFF_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FILT, S_FWAIT, S_ROUND, S_ROT, S_RWAIT, S_OUT
  } state_t;

  state_t   state;
  reg_idx_t step;
  reg_idx_t pstep;
  logic     pv;

  logic signed [SAMPLE_WIDTH-1:0] u0, u1, u2;
  logic signed [OUT_W-1:0]        y1, y2, y_cur;
  logic signed [OUT_W-1:0]        body_x, body_y, body_z;
  logic signed [OUT_W-1:0]        out_x, out_y, out_z;
  logic signed [ACC_W-1:0]        acc;
  logic signed [PROD_W-1:0]       prod;

  logic signed [COEFF_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]        mul_b;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W:0]          round_f;
  logic signed [ACC_W-SUM_DROP:0] y_q;
  logic signed [PROD_W:0]         round_r;
  logic signed [PROD_W-COEFF_FRAC_BITS:0] r_q;
  logic signed [OUT_W-1:0]        y_sat;
  logic signed [OUT_W-1:0]        r_sat;
  logic                           load_out;

  assign pop   = (state == S_IDLE) && head_valid;
  assign mul_a = signed'(coeffs[step]);

  // output register is free, or is being emptied this cycle
  assign load_out = (state == S_OUT) && (!results.valid || results.ready);

  always_comb begin
    case (step)
      REG_COEFF_A: mul_b = MUL_W'(u0);
      REG_COEFF_B: mul_b = MUL_W'(u1);
      REG_COEFF_C: mul_b = MUL_W'(u2);
      REG_COEFF_D: mul_b = MUL_W'(y1);
      REG_COEFF_E: mul_b = MUL_W'(y2);
      default:     mul_b = MUL_W'(y_cur);
    endcase
  end

  assign prod_ext = ACC_W'(prod);
  assign round_f  = (ACC_W+1)'(acc) + HALF_F;
  assign y_q      = (ACC_W-SUM_DROP+1)'(round_f >>> SUM_DROP);
  assign y_sat    = sat24(64'(y_q));
  assign round_r  = (PROD_W+1)'(prod) + HALF_R;
  assign r_q      = (PROD_W-COEFF_FRAC_BITS+1)'(round_r >>> COEFF_FRAC_BITS);
  assign r_sat    = sat24(64'(r_q));

  assign results.body_x = out_x;
  assign results.body_y = out_y;
  assign results.body_z = out_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= REG_COEFF_A;
      pstep           <= REG_COEFF_A;
      pv              <= 1'b0;
      u1              <= '0;
      u2              <= '0;
      y1              <= '0;
      y2              <= '0;
      results.valid   <= 1'b0;
    end else begin
      pv <= (state == S_FILT) || (state == S_ROT);

      // product from the previous cycle lands here
      if (pv) begin
        case (pstep)
          REG_COEFF_A, REG_COEFF_B, REG_COEFF_C: acc <= acc + (prod_ext <<< U_SHIFT);
          REG_COEFF_D, REG_COEFF_E:              acc <= acc - (prod_ext <<< Y_SHIFT);
          REG_ROT_X:                             body_x <= r_sat;
          REG_ROT_Y:                             body_y <= r_sat;
          default:                               body_z <= r_sat;
        endcase
      end

      if (load_out) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (head_valid) begin
            u0    <= head_sample;
            acc   <= '0;
            step  <= REG_COEFF_A;
            state <= S_FILT;
          end
        end
        S_FILT, S_ROT: begin
          prod  <= mul_a * mul_b;
          pstep <= step;
          step  <= reg_idx_t'(step + 3'd1);
          if (step == REG_COEFF_E) begin
            state <= S_FWAIT;
          end else if (step == REG_ROT_Z) begin
            state <= S_RWAIT;
          end
        end
        S_FWAIT: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          y_cur <= y_sat;
          y1    <= y_sat;
          y2    <= y1;
          u1    <= u0;
          u2    <= u1;
          state <= S_ROT;
        end
        S_RWAIT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // body components are staged so a stalled result keeps its fields
          if (load_out) begin
            results.filtered <= y_cur;
            out_x            <= body_x;
            out_y            <= body_y;
            out_z            <= body_z;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/biquad_filter_frame_rotate.sv =====
// ----------------------------------------------------------------------------
// biquad_filter_frame_rotate: second-order IIR filter with body-frame rotation
// Each Q1.15 sample transaction is filtered in direct form I with Q2.14
// coefficients (y = a*u0 + b*u1 + c*u2 - d*y1 - e*y2), rounded half up to
// Q4.20 and saturated to 24 bits; the result is then scaled by the three
// navigation-x direction cosines and each body component is rounded and
// saturated the same way. One result transaction follows every sample.
// The shared 16-bit by max(SAMPLE_WIDTH,24)-bit multiplier performs the
// five filter and three rotation products in turn, around the queue pop,
// accumulate drains, rounding and output load; a sample is not started
// until the previous result is loaded for output. Samples are buffered in
// a two-entry queue, so until it fills intake goes on while the datapath
// works or a finished result waits in the output register. The user must
// write coefficients through cfg_we/cfg_index/cfg_data only while the
// block is idle, unenforced by the block; rst resets histories and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_filter_frame_rotate #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  bqfr_sample_if.sink                                samples,
  bqfr_result_if.source                              results,
  input  wire logic                                  cfg_we,
  input  wire logic [bqfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bqfr_pkg::COEFF_W-1:0]          cfg_data
);
  import bqfr_pkg::*;

  coeff_bank_t                    coeffs;
  logic                           head_valid;
  logic signed [SAMPLE_WIDTH-1:0] head_sample;
  logic                           pop;

  // Register bank; all eight indexes are live, so every write lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= CFG_RESET;
    end else if (cfg_we) begin
      coeffs[cfg_index] <= cfg_data;
    end
  end

  // Front: sample intake queue.
  bqfr_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .head_valid  (head_valid),
    .head_sample (head_sample),
    .pop         (pop)
  );

  // Back: filter, history update, rotation and output register.
  bqfr_back #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_sample (head_sample),
    .pop         (pop),
    .coeffs      (coeffs),
    .results     (results)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bqfr_checker.sv =====
// ----------------------------------------------------------------------------
// bqfr_checker: port-level checks for the biquad block
// Tracks transactions in flight and checks for spurious results, the backlog bound, idle readiness and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] filtered,
  input wire logic [23:0] body_x
);
  logic [3:0] in_flight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 4'd0;
    end else begin
      in_flight <= in_flight + 4'(in_acc) - 4'(out_acc);
    end
  end

  // no result without a sample behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 4'd0)
    else $error("result with no sample outstanding");

  // queue plus datapath plus output register bounds the backlog
  a_backlog: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 4'd4)
    else $error("more transactions in flight than the block can hold");

  // an empty block always takes a sample
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    in_flight == 4'd0 |-> in_ready)
    else $error("idle block refuses a sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(body_x))
    else $error("stalled result changed");

endmodule

bind biquad_filter_frame_rotate bqfr_checker u_bqfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .filtered  (results.filtered),
  .body_x    (results.body_x)
);

`default_nettype wire
